>>> rtl/wmbh_pkg.sv
// ============================================================================
// wmbh_pkg
// Shared types and constants for the word mix buffer hash unit.
// ============================================================================
package wmbh_pkg;

    // Seed of the running value, restored after every message
    localparam logic [63:0] MIX_SEED = 64'd123456789;

    // Most tail bytes one final item can carry
    localparam logic [3:0] TAIL_MAX = 4'd8;

    // Number of unit operations in each phase
    localparam int FOLD_STEPS = 7;
    localparam int MIX_STEPS  = 3;
    localparam int FIN_STEPS  = 3;

    // Operations of the shared add/xor-shift unit
    typedef enum logic [3:0] {
        OP_ADD_WORD,
        OP_ADD_SHL32,
        OP_ADD_SHR32,
        OP_ADD_SHL10,
        OP_XOR_SHR6,
        OP_XOR_SHL48,
        OP_XOR_SEED,
        OP_ADD_BYTE,
        OP_ADD_SHL3,
        OP_XOR_SHR11,
        OP_ADD_SHL15
    } op_t;

    // Control handed from the sequencer to the shared unit
    typedef struct packed {
        op_t  op;
        logic narrow;
    } alu_ctrl_t;

endpackage

>>> rtl/wmbh_alu.sv
// ============================================================================
// wmbh_alu
// Shared add/xor-shift unit: one operation on the running value per cycle.
// ============================================================================
module wmbh_alu
    import wmbh_pkg::*;
(
    input  alu_ctrl_t   ctrl,
    input  logic [63:0] acc,
    input  logic [63:0] word,
    input  logic [7:0]  tail_byte,
    output logic [63:0] result
);

    logic [63:0] opnd;
    logic        use_xor;
    logic [63:0] raw;

    // Pick the second operand and the combining operation
    always_comb
    begin
        opnd    = '0;
        use_xor = 1'b0;
        case (ctrl.op)
            OP_ADD_WORD:  opnd = word;
            OP_ADD_SHL32: opnd = acc << 32;
            OP_ADD_SHR32: opnd = acc >> 32;
            OP_ADD_SHL10: opnd = acc << 10;
            OP_XOR_SHR6:
            begin
                opnd    = acc >> 6;
                use_xor = 1'b1;
            end
            OP_XOR_SHL48:
            begin
                opnd    = acc << 48;
                use_xor = 1'b1;
            end
            OP_XOR_SEED:
            begin
                opnd    = MIX_SEED;
                use_xor = 1'b1;
            end
            // byte is a signed char widened to 32 bits
            OP_ADD_BYTE:  opnd = {32'd0, {24{tail_byte[7]}}, tail_byte};
            OP_ADD_SHL3:  opnd = acc << 3;
            OP_XOR_SHR11:
            begin
                opnd    = acc >> 11;
                use_xor = 1'b1;
            end
            OP_ADD_SHL15: opnd = acc << 15;
            default:      opnd = '0;
        endcase
    end

    assign raw = use_xor ? (acc ^ opnd) : (acc + opnd);

    // Keep 32-bit arithmetic clean for the next right shift
    assign result = ctrl.narrow ? {32'd0, raw[31:0]} : raw;

endmodule

>>> rtl/word_mix_buffer_hash_unit.sv
// ============================================================================
// word_mix_buffer_hash_unit
// Message hash over 64-bit words with a byte-wise tail and 32-bit result.
// ============================================================================
//
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+--------------------------------
// in      | input     | in_valid/in_stall  | data_word, byte_count, final_item
// out     | output    | out_valid/out_stall| hash_value
//
// A full word is accepted and then folded by seven add/xor-shift steps in
// the shared unit. A final item with n tail bytes (n saturated to 8) is
// accepted, then takes three unit steps per byte, three finalize steps,
// and a load of the output register once that register is free.
// Reset returns the running value to the seed and drops any pending result.
// An input item is taken while a finished hash still waits on out_stall;
// the next hash holds in the sequencer until the output register is free.
module word_mix_buffer_hash_unit
    import wmbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        final_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_MIX,
        S_FIN,
        S_EMIT
    } state_t;

    localparam logic [2:0] FOLD_LAST = 3'(FOLD_STEPS - 1);
    localparam logic [2:0] MIX_LAST  = 3'(MIX_STEPS - 1);
    localparam logic [2:0] FIN_LAST  = 3'(FIN_STEPS - 1);

    state_t      state_reg;
    logic [2:0]  step_reg;
    logic [3:0]  idx_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] word_reg;
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    alu_ctrl_t   ctrl;
    logic [63:0] alu_result;
    logic [7:0]  tail_byte;
    logic [3:0]  cnt_next;
    logic        in_take;
    logic        out_free;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Saturate the tail length at eight bytes
    assign cnt_next = (byte_count > TAIL_MAX) ? TAIL_MAX : byte_count;

    // Select the current tail byte, lowest first
    assign tail_byte = word_reg[{idx_reg[2:0], 3'b000} +: 8];

    // Decode the unit operation from phase and step
    always_comb
    begin
        ctrl.narrow = (state_reg == S_MIX) || (state_reg == S_FIN);
        ctrl.op     = OP_XOR_SEED;
        case (state_reg)
            S_FOLD:
            begin
                case (step_reg)
                    3'd0:    ctrl.op = OP_ADD_WORD;
                    3'd1:    ctrl.op = OP_ADD_SHL32;
                    3'd2:    ctrl.op = OP_ADD_SHR32;
                    3'd3:    ctrl.op = OP_ADD_SHL10;
                    3'd4:    ctrl.op = OP_XOR_SHR6;
                    3'd5:    ctrl.op = OP_XOR_SHL48;
                    default: ctrl.op = OP_XOR_SEED;
                endcase
            end
            S_MIX:
            begin
                case (step_reg)
                    3'd0:    ctrl.op = OP_ADD_BYTE;
                    3'd1:    ctrl.op = OP_ADD_SHL10;
                    default: ctrl.op = OP_XOR_SHR6;
                endcase
            end
            S_FIN:
            begin
                case (step_reg)
                    3'd0:    ctrl.op = OP_ADD_SHL3;
                    3'd1:    ctrl.op = OP_XOR_SHR11;
                    default: ctrl.op = OP_ADD_SHL15;
                endcase
            end
            default: ctrl.op = OP_XOR_SEED;
        endcase
    end

    wmbh_alu u_alu (
        .ctrl      (ctrl),
        .acc       (acc_reg),
        .word      (word_reg),
        .tail_byte (tail_byte),
        .result    (alu_result)
    );

    // Sequence the shared unit and hold the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= MIX_SEED;
            word_reg      <= '0;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new result, or drop the old one once it is taken
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        word_reg <= data_word;
                        step_reg <= '0;
                        idx_reg  <= '0;
                        cnt_reg  <= cnt_next;
                        if (final_item)
                        begin
                            acc_reg   <= {32'd0, acc_reg[31:0]};
                            state_reg <= (cnt_next == 4'd0) ? S_FIN : S_MIX;
                        end
                        else
                        begin
                            state_reg <= S_FOLD;
                        end
                    end
                end
                S_FOLD:
                begin
                    acc_reg  <= alu_result;
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == FOLD_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MIX:
                begin
                    acc_reg <= alu_result;
                    if (step_reg == MIX_LAST)
                    begin
                        step_reg <= '0;
                        idx_reg  <= idx_reg + 4'd1;
                        if (idx_reg + 4'd1 == cnt_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_FIN:
                begin
                    acc_reg  <= alu_result;
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == FIN_LAST)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        hash_reg  <= acc_reg[31:0];
                        acc_reg   <= MIX_SEED;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted item always keeps the block busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("block not busy after taking an item");

    // A new result comes only from the emit step
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    // Tail position stays inside the tail while mixing
    a_idx_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) |-> (idx_reg < cnt_reg && cnt_reg <= TAIL_MAX))
        else $error("tail byte index out of range");

    // Emitting a hash restores the seed
    a_seed_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (acc_reg == MIX_SEED))
        else $error("running value not reseeded");

endmodule
